// ===== design/svp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types, codes, widths and reset values of the sample playback voice.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int BUFFER_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int MAX_CHANNELS_DEF = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RATE_W     = 19;
    localparam int FRAME_W    = 32;
    localparam int OFFSET_W   = 16;
    localparam int BLEN_W     = 17;
    localparam int CCNT_W     = 2;
    localparam int REQ_W      = 2;
    localparam int ADDR_IN_W  = 16;

    localparam logic              LOOP_MODE_RST   = 1'b0;
    localparam logic [RATE_W-1:0] RATE_RST        = 19'd65536;
    localparam logic [FRAME_W-1:0] START_FRAME_RST = '0;
    localparam logic [FRAME_W-1:0] PLAY_END_RST    = '1;
    localparam logic [FRAME_W-1:0] STOP_FRAME_RST  = '1;
    localparam logic [OFFSET_W-1:0] OFFSET_RST     = '0;
    localparam logic [BLEN_W-1:0] BLEN_RST        = 17'd65536;
    localparam logic [CCNT_W-1:0] CCNT_RST        = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_MODE,
        CFG_PLAYBACK_RATE,
        CFG_START_FRAME,
        CFG_PLAY_END_FRAME,
        CFG_STOP_FRAME,
        CFG_START_OFFSET,
        CFG_BUFFER_LENGTH,
        CFG_CHANNEL_COUNT
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_RENDER,
        REQ_WRITE,
        REQ_ATTACH,
        REQ_ARM
    } t_req;

    typedef enum logic [1:0] {
        VS_UNSCHEDULED,
        VS_SCHEDULED,
        VS_PLAYING,
        VS_FINISHED
    } t_voice;

    typedef enum logic [1:0] {
        RC_IDLE,
        RC_RATE,
        RC_OFFSET,
        RC_POS
    } t_rc_state;

    // per-item sideband that travels with the lanes
    typedef struct packed {
        logic silent;
        logic finished;
        logic playing;
        logic stereo;
    } t_item_flags;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rc_status;

endpackage

// ===== design/svp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== design/svp_recalc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_recalc
// Bit-serial restoring modulo unit. Reduces the playback rate, the start
// offset and the held read position modulo the current span, one after the
// other, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module svp_recalc #(
    parameter int FRAC_BITS = svp_pkg::FRAC_BITS_DEF,
    parameter int POS_W     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [POS_W:0]                 i_span,
    input  logic [svp_pkg::RATE_W-1:0]     i_rate,
    input  logic [svp_pkg::OFFSET_W-1:0]   i_offset,
    input  logic [POS_W-1:0]               i_pos,
    output logic [POS_W-1:0]               o_rate_mod,
    output logic [POS_W-1:0]               o_off_pos,
    output logic [POS_W-1:0]               o_pos_mod,
    output svp_pkg::t_rc_status            o_status
);
    import svp_pkg::*;

    localparam int OFF_W = OFFSET_W + FRAC_BITS;
    localparam int DW0   = (POS_W > OFF_W) ? POS_W : OFF_W;
    localparam int DW    = (DW0 > RATE_W) ? DW0 : RATE_W;
    localparam int BW    = $clog2(DW);

    t_rc_state         r_state;
    t_rc_state         n_state;
    logic [BW-1:0]     r_bit;
    logic [POS_W-1:0]  r_rem;
    logic              r_done;
    logic [POS_W-1:0]  r_rate_mod;
    logic [POS_W-1:0]  r_off_pos;
    logic [POS_W-1:0]  r_pos_mod;

    logic [DW-1:0]     w_dividend;
    logic [POS_W:0]    w_trial;
    logic [POS_W-1:0]  w_rem_next;
    logic              w_last;

    always_comb begin
        case (r_state)
            RC_RATE:   w_dividend = DW'(i_rate);
            RC_OFFSET: w_dividend = DW'({i_offset, {FRAC_BITS{1'b0}}});
            RC_POS:    w_dividend = DW'(i_pos);
            default:   w_dividend = '0;
        endcase
    end

    // shift in the next dividend bit, subtract the span where it fits
    assign w_trial    = {r_rem, w_dividend[r_bit]};
    assign w_rem_next = (w_trial >= i_span) ? POS_W'(w_trial - i_span) : POS_W'(w_trial);
    assign w_last     = (r_bit == '0);

    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = RC_RATE;
        end else begin
            case (r_state)
                RC_IDLE:   n_state = RC_IDLE;
                RC_RATE:   if (w_last) n_state = RC_OFFSET;
                RC_OFFSET: if (w_last) n_state = RC_POS;
                RC_POS:    if (w_last) n_state = RC_IDLE;
                default:   n_state = RC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RC_IDLE;
            r_done  <= 1'b0;
            r_bit   <= BW'(DW - 1);
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == RC_POS) && w_last && !i_start;
            if (i_start || (r_state == RC_IDLE) || w_last) begin
                r_bit <= BW'(DW - 1);
                r_rem <= '0;
            end else begin
                r_bit <= r_bit - BW'(1);
                r_rem <= w_rem_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_start && w_last) begin
            case (r_state)
                RC_RATE:   r_rate_mod <= w_rem_next;
                RC_OFFSET: r_off_pos  <= w_rem_next;
                RC_POS:    r_pos_mod  <= w_rem_next;
                default:   ;
            endcase
        end
    end

    assign o_rate_mod      = r_rate_mod;
    assign o_off_pos       = r_off_pos;
    assign o_pos_mod       = r_pos_mod;
    assign o_status.busy   = (r_state != RC_IDLE) || r_done;
    assign o_status.done   = r_done;

endmodule

// ===== design/svp_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_lane
// One channel lane: sample store, neighbour read, difference, multiply by
// the position fraction and final interpolation sum.
// ----------------------------------------------------------------------------
module svp_lane #(
    parameter int DEPTH       = svp_pkg::BUFFER_DEPTH_DEF,
    parameter int FRAC_BITS   = svp_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = svp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]        i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr0,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr1,
    input  logic                          i_en2,
    input  logic                          i_en3,
    input  logic [FRAC_BITS-1:0]          i_frac,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

    logic [SAMPLE_BITS-1:0]        w_rd0;
    logic [SAMPLE_BITS-1:0]        w_rd1;
    logic signed [SAMPLE_BITS:0]   r_diff;
    logic [SAMPLE_BITS-1:0]        r_s0_2;
    logic signed [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0]        r_s0_3;
    logic signed [PW-1:0]          w_q;
    logic [SAMPLE_BITS+1:0]        w_sum;

    svp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (i_wr_en),
        .i_wr_addr   (i_wr_addr),
        .i_wr_data   (i_wr_data),
        .i_rd_en     (i_rd_en),
        .i_rd_addr_a (i_rd_addr0),
        .i_rd_addr_b (i_rd_addr1),
        .o_rd_data_a (w_rd0),
        .o_rd_data_b (w_rd1)
    );

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_diff <= $signed({w_rd1[SAMPLE_BITS-1], w_rd1})
                    - $signed({w_rd0[SAMPLE_BITS-1], w_rd0});
            r_s0_2 <= w_rd0;
        end
        if (i_en3) begin
            r_prod <= r_diff * $signed({1'b0, i_frac});
            r_s0_3 <= r_s0_2;
        end
    end

    // arithmetic shift gives the floor of the scaled difference
    assign w_q      = r_prod >>> FRAC_BITS;
    assign w_sum    = {r_s0_3[SAMPLE_BITS-1], r_s0_3[SAMPLE_BITS-1], r_s0_3}
                    + w_q[SAMPLE_BITS+1:0];
    assign o_sample = w_sum[SAMPLE_BITS-1:0];

endmodule

// ===== design/sample_playback_voice_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_playback_voice_core
// One-voice sample player with per-channel lanes and linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   config channel (i_cfg_*): one register write per transfer, always ready;
//   write only while the voice has no item in flight.
//   input channel (i_in_*): render, sample write, attach or arm requests.
//   output channel (o_out_*): exactly one result per input transfer, in order.
// Pipeline: read, difference, product and output registers. Throughput: one
//   item per cycle when not stalled, set by the position update (one add and
//   compare-subtract) and the dual-read sample memory per lane.
// Reset and config writes: a bit-serial modulo pass reduces rate, offset and
//   position against the buffer span over max(log2(depth) + frac, 16 + frac,
//   19) dividend bits each; o_in_ready is low meanwhile.
//   Sample memory is not cleared; samples must be written before playback.
// Stall: while the receiver holds off, the internal stages keep filling and
//   o_in_ready drops once four results are held.
// ----------------------------------------------------------------------------
module sample_playback_voice_core #(
    parameter int BUFFER_DEPTH = svp_pkg::BUFFER_DEPTH_DEF,
    parameter int FRAC_BITS    = svp_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS  = svp_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_CHANNELS = svp_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [svp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [svp_pkg::REQ_W-1:0]         i_req_type,
    input  logic                              i_sample_channel,
    input  logic [svp_pkg::ADDR_IN_W-1:0]     i_sample_address,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_left_out,
    output logic signed [SAMPLE_BITS-1:0]     o_right_out,
    output logic                              o_silent,
    output logic                              o_finished,
    output logic                              o_playing
);
    import svp_pkg::*;

    localparam int AW     = $clog2(BUFFER_DEPTH);
    localparam int LEN_W  = AW + 1;
    localparam int POS_W  = AW + FRAC_BITS;
    localparam int SPAN_W = POS_W + 1;

    // configuration registers
    logic                 r_loop_mode;
    logic [RATE_W-1:0]    r_rate;
    logic [FRAME_W-1:0]   r_start_frame;
    logic [FRAME_W-1:0]   r_play_end;
    logic [FRAME_W-1:0]   r_stop_frame;
    logic [OFFSET_W-1:0]  r_start_offset;
    logic [BLEN_W-1:0]    r_buffer_length;
    logic [CCNT_W-1:0]    r_channel_count;

    // derived settings, refreshed every cycle
    logic [LEN_W-1:0]     w_len;
    logic [LEN_W-1:0]     r_len;
    logic [SPAN_W-1:0]    r_span;
    logic [FRAME_W-1:0]   r_end;
    logic                 r_stereo;

    // voice state
    t_voice               r_voice;
    t_voice               n_voice;
    t_voice               w_voice_mid;
    logic                 r_attached;
    logic                 n_attached;
    logic [FRAME_W-1:0]   r_frame;
    logic [FRAME_W-1:0]   n_frame;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [POS_W-1:0]     r_pos_raw;
    logic [POS_W-1:0]     n_pos_raw;

    // modulo pass
    logic                 r_kick;
    logic                 r_start;
    logic [POS_W-1:0]     w_rc_rate;
    logic [POS_W-1:0]     w_rc_off;
    logic [POS_W-1:0]     w_rc_pos;
    t_rc_status           w_rc_status;

    // front end
    t_req                 w_req;
    t_item_flags          w_flags;
    logic [SPAN_W-1:0]    w_pos_sum;
    logic [POS_W-1:0]     w_pos_step;
    logic [AW-1:0]        w_idx;
    logic [LEN_W-1:0]     w_idx_inc;
    logic [AW-1:0]        w_nxt;
    logic                 w_wr_ok;
    logic                 w_busy;
    logic                 w_accept;

    // pipeline
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 r_vo;
    logic                 w_mv2;
    logic                 w_mv3;
    logic                 w_mv_o;
    t_item_flags          r_f1;
    t_item_flags          r_f2;
    t_item_flags          r_f3;
    logic [FRAC_BITS-1:0] r_frac1;
    logic [FRAC_BITS-1:0] r_frac2;
    logic signed [SAMPLE_BITS-1:0] w_lane_sample [MAX_CHANNELS];

    // output register
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                 r_silent;
    logic                 r_finished;
    logic                 r_playing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_mode     <= LOOP_MODE_RST;
            r_rate          <= RATE_RST;
            r_start_frame   <= START_FRAME_RST;
            r_play_end      <= PLAY_END_RST;
            r_stop_frame    <= STOP_FRAME_RST;
            r_start_offset  <= OFFSET_RST;
            r_buffer_length <= BLEN_RST;
            r_channel_count <= CCNT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOOP_MODE:      r_loop_mode     <= i_cfg_data[0];
                CFG_PLAYBACK_RATE:  r_rate          <= i_cfg_data[RATE_W-1:0];
                CFG_START_FRAME:    r_start_frame   <= i_cfg_data[FRAME_W-1:0];
                CFG_PLAY_END_FRAME: r_play_end      <= i_cfg_data[FRAME_W-1:0];
                CFG_STOP_FRAME:     r_stop_frame    <= i_cfg_data[FRAME_W-1:0];
                CFG_START_OFFSET:   r_start_offset  <= i_cfg_data[OFFSET_W-1:0];
                CFG_BUFFER_LENGTH:  r_buffer_length <= i_cfg_data[BLEN_W-1:0];
                CFG_CHANNEL_COUNT:  r_channel_count <= i_cfg_data[CCNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // zero length acts as one, oversize as the full depth
    always_comb begin
        if (r_buffer_length == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_buffer_length) > 32'(BUFFER_DEPTH)) begin
            w_len = LEN_W'(BUFFER_DEPTH);
        end else begin
            w_len = LEN_W'(r_buffer_length);
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= w_len;
        r_span   <= {w_len, {FRAC_BITS{1'b0}}};
        r_end    <= (!r_loop_mode && (r_play_end < r_stop_frame)) ? r_play_end : r_stop_frame;
        r_stereo <= (MAX_CHANNELS >= 2) && (r_channel_count >= CCNT_W'(2));
    end

    // kick the modulo pass through r_kick and r_start so that it sees the refreshed span
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick  <= 1'b1;
            r_start <= 1'b0;
        end else begin
            r_kick  <= i_cfg_valid;
            r_start <= r_kick;
        end
    end

    svp_recalc #(
        .FRAC_BITS (FRAC_BITS),
        .POS_W     (POS_W)
    ) u_recalc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_span     (r_span),
        .i_rate     (r_rate),
        .i_offset   (r_start_offset),
        .i_pos      (r_pos_raw),
        .o_rate_mod (w_rc_rate),
        .o_off_pos  (w_rc_off),
        .o_pos_mod  (w_rc_pos),
        .o_status   (w_rc_status)
    );

    // handshake and stage movement
    assign w_mv_o     = !r_vo || i_out_ready;
    assign w_mv3      = !r_v3 || w_mv_o;
    assign w_mv2      = !r_v2 || w_mv3;
    assign w_busy     = w_rc_status.busy || r_kick || r_start;
    assign o_in_ready = !w_busy && (!r_v1 || w_mv2);
    assign w_accept   = i_in_valid && o_in_ready;

    // read addresses and position step
    assign w_idx      = r_pos[POS_W-1:FRAC_BITS];
    assign w_idx_inc  = LEN_W'(w_idx) + LEN_W'(1);
    assign w_nxt      = (w_idx_inc >= r_len) ? '0 : w_idx_inc[AW-1:0];
    assign w_pos_sum  = SPAN_W'(r_pos) + SPAN_W'(w_rc_rate);
    assign w_pos_step = (w_pos_sum >= r_span) ? POS_W'(w_pos_sum - r_span)
                                              : POS_W'(w_pos_sum);

    assign w_req   = t_req'(i_req_type);
    assign w_wr_ok = w_accept && (w_req == REQ_WRITE)
                  && (32'(i_sample_address) < 32'(BUFFER_DEPTH));

    always_comb begin
        n_voice          = r_voice;
        w_voice_mid      = r_voice;
        n_attached       = r_attached;
        n_frame          = r_frame;
        n_pos            = r_pos;
        n_pos_raw        = r_pos_raw;
        w_flags.silent   = 1'b1;
        w_flags.finished = 1'b0;
        w_flags.stereo   = r_stereo;
        case (w_req)
            REQ_RENDER: begin
                n_frame = r_frame + FRAME_W'(1);
                if (r_attached && (r_voice == VS_SCHEDULED) && (r_start_frame <= r_frame)) begin
                    w_voice_mid = VS_PLAYING;
                end
                n_voice = w_voice_mid;
                if (r_attached && (w_voice_mid == VS_PLAYING)) begin
                    if (r_end < r_frame) begin
                        n_voice          = VS_FINISHED;
                        w_flags.finished = 1'b1;
                    end else begin
                        if (r_end == r_frame) begin
                            n_voice          = VS_FINISHED;
                            w_flags.finished = 1'b1;
                        end
                        w_flags.silent = 1'b0;
                        n_pos          = w_pos_step;
                        n_pos_raw      = w_pos_step;
                    end
                end
            end
            REQ_WRITE: begin
                n_voice = r_voice;
            end
            REQ_ATTACH: begin
                n_attached = 1'b1;
                n_voice    = VS_UNSCHEDULED;
                n_pos      = '0;
                n_pos_raw  = '0;
            end
            REQ_ARM: begin
                if (r_attached) begin
                    n_voice   = VS_SCHEDULED;
                    n_pos     = w_rc_off;
                    n_pos_raw = w_rc_off;
                end
            end
            default: ;
        endcase
        w_flags.playing = (n_voice == VS_PLAYING);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice    <= VS_UNSCHEDULED;
            r_attached <= 1'b0;
            r_frame    <= '0;
            r_pos      <= '0;
            r_pos_raw  <= '0;
        end else if (w_rc_status.done) begin
            r_pos <= w_rc_pos;
        end else if (w_accept) begin
            r_voice    <= n_voice;
            r_attached <= n_attached;
            r_frame    <= n_frame;
            r_pos      <= n_pos;
            r_pos_raw  <= n_pos_raw;
        end
    end

    // channel lanes
    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        svp_lane #(
            .DEPTH       (BUFFER_DEPTH),
            .FRAC_BITS   (FRAC_BITS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_wr_en    (w_wr_ok && (int'(i_sample_channel) == c)),
            .i_wr_addr  (AW'(i_sample_address)),
            .i_wr_data  (i_sample_value),
            .i_rd_en    (w_accept),
            .i_rd_addr0 (w_idx),
            .i_rd_addr1 (w_nxt),
            .i_en2      (w_mv2),
            .i_en3      (w_mv3),
            .i_frac     (r_frac2),
            .o_sample   (w_lane_sample[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= w_accept || (r_v1 && !w_mv2);
            if (w_mv2) r_v2 <= r_v1;
            if (w_mv3) r_v3 <= r_v2;
            if (w_mv_o) r_vo <= r_v3;
        end
    end

    // sideband pipeline and merge: silence and mono gating of the lane results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1    <= w_flags;
            r_frac1 <= r_pos[FRAC_BITS-1:0];
        end
        if (w_mv2) begin
            r_f2    <= r_f1;
            r_frac2 <= r_frac1;
        end
        if (w_mv3) begin
            r_f3 <= r_f2;
        end
        if (w_mv_o) begin
            r_left     <= r_f3.silent ? '0 : w_lane_sample[0];
            r_right    <= (r_f3.silent || !r_f3.stereo) ? '0 : w_lane_sample[MAX_CHANNELS-1];
            r_silent   <= r_f3.silent;
            r_finished <= r_f3.finished;
            r_playing  <= r_f3.playing;
        end
    end

    assign o_out_valid = r_vo;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;
    assign o_silent    = r_silent;
    assign o_finished  = r_finished;
    assign o_playing   = r_playing;

`ifndef NO_ASSERTIONS
    a_pos_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_busy |-> ({1'b0, r_pos} < r_span))
        else $error("read position outside buffer span");

    a_state_needs_attach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_voice != VS_UNSCHEDULED) |-> r_attached)
        else $error("voice left unscheduled without an attached buffer");

    a_finish_not_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> !o_playing)
        else $error("completion flagged while still playing");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_silent) |-> ((o_left_out == '0) && (o_right_out == '0)))
        else $error("silent result carries audio");

    a_pos_loaded_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rc_status.done |=> (r_pos == $past(w_rc_pos)))
        else $error("reduced position not taken over");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample playback voice core.
// A short directed run covers field extremes and the voice corner cases. After
// that, random register settings and note sequences follow under three
// handshake pacing patterns. Each accepted request updates an in-bench voice
// model that predicts the output frame, and every frame is compared field by
// field in order.
// ----------------------------------------------------------------------------
module tb;
    import svp_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int DEPTH        = BUFFER_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               silent;
        logic               finished;
        logic               playing;
    } t_voice_frame;

    class voice_scoreboard;
        logic signed [15:0] mem [2][DEPTH];
        bit                 written [2][DEPTH];
        bit [63:0]          pos;
        logic [31:0]        frame_no;
        t_voice             voice;
        bit                 attached;

        logic               loop_on;
        logic [18:0]        rate;
        logic [31:0]        start_at;
        logic [31:0]        play_end;
        logic [31:0]        stop_at;
        logic [15:0]        offset;
        logic [16:0]        blen;
        logic [1:0]         chans;

        t_voice_frame       pending [$];
        int                 errors;
        int                 n_checked;
        int                 n_audible;
        int                 n_done;

        function new();
            pos      = '0;
            frame_no = '0;
            voice    = VS_UNSCHEDULED;
            attached = 1'b0;
            loop_on  = LOOP_MODE_RST;
            rate     = RATE_RST;
            start_at = START_FRAME_RST;
            play_end = PLAY_END_RST;
            stop_at  = STOP_FRAME_RST;
            offset   = OFFSET_RST;
            blen     = BLEN_RST;
            chans    = CCNT_RST;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 100) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                CFG_LOOP_MODE:      loop_on  = d[0];
                CFG_PLAYBACK_RATE:  rate     = d[18:0];
                CFG_START_FRAME:    start_at = d;
                CFG_PLAY_END_FRAME: play_end = d;
                CFG_STOP_FRAME:     stop_at  = d;
                CFG_START_OFFSET:   offset   = d[15:0];
                CFG_BUFFER_LENGTH:  blen     = d[16:0];
                CFG_CHANNEL_COUNT:  chans    = d[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_len();
            if (blen == 0) return 1;
            if (blen > DEPTH) return DEPTH;
            return blen;
        endfunction

        function int eff_chans();
            if (chans == 0) return 1;
            if (chans > 2) return 2;
            return chans;
        endfunction

        function logic [31:0] last_frame();
            logic [31:0] e;
            e = stop_at;
            if (!loop_on && play_end < e) e = play_end;
            return e;
        endfunction

        // true when the next render frame will read sample memory
        function bit will_play();
            bit live;
            live = attached && (voice == VS_PLAYING ||
                                (voice == VS_SCHEDULED && start_at <= frame_no));
            return live && !(last_frame() < frame_no);
        endfunction

        function void locate(output int unsigned idx, output int unsigned nxt,
                             output bit [63:0] frac, output bit [63:0] p);
            bit [63:0] span;
            span = 64'(eff_len()) << FRAC;
            p    = (pos >= span) ? pos % span : pos;
            idx  = int'(p >> FRAC);
            frac = p & ((64'd1 << FRAC) - 1);
            nxt  = (idx + 1 >= eff_len()) ? 0 : idx + 1;
        endfunction

        function logic signed [15:0] lerp(int ch, int unsigned idx, int unsigned nxt,
                                          bit [63:0] frac);
            longint s0, s1, prod;
            s0   = mem[ch][idx];
            s1   = mem[ch][nxt];
            prod = (s1 - s0) * longint'(frac);
            // arithmetic shift gives the floor for negative products
            return 16'(s0 + (prod >>> FRAC));
        endfunction

        function void note(t_req req, logic ch, logic [15:0] addr, logic [15:0] val);
            t_voice_frame f;
            logic [31:0]  t;
            logic [31:0]  e;
            int unsigned  idx, nxt;
            bit [63:0]    frac, p, span;
            f.left     = '0;
            f.right    = '0;
            f.silent   = 1'b1;
            f.finished = 1'b0;
            case (req)
                REQ_WRITE: begin
                    mem[ch][addr]     = val;
                    written[ch][addr] = 1'b1;
                end
                REQ_ATTACH: begin
                    attached = 1'b1;
                    voice    = VS_UNSCHEDULED;
                    pos      = '0;
                end
                REQ_ARM: begin
                    if (attached) begin
                        pos   = 64'(offset % eff_len()) << FRAC;
                        voice = VS_SCHEDULED;
                    end
                end
                default: begin
                    t = frame_no;
                    if (attached && voice == VS_SCHEDULED && start_at <= t) voice = VS_PLAYING;
                    if (attached && voice == VS_PLAYING) begin
                        e = last_frame();
                        if (e < t) begin
                            voice      = VS_FINISHED;
                            f.finished = 1'b1;
                        end else begin
                            if (e == t) begin
                                voice      = VS_FINISHED;
                                f.finished = 1'b1;
                            end
                            locate(idx, nxt, frac, p);
                            f.left = lerp(0, idx, nxt, frac);
                            if (eff_chans() == 2) f.right = lerp(1, idx, nxt, frac);
                            f.silent = 1'b0;
                            span = 64'(eff_len()) << FRAC;
                            pos  = p + rate;
                            if (pos > (64'(eff_len() - 1) << FRAC)) pos = pos % span;
                        end
                    end
                    frame_no = t + 1;
                end
            endcase
            f.playing = (voice == VS_PLAYING);
            pending.push_back(f);
        endfunction

        function void check(t_voice_frame got);
            t_voice_frame want;
            if (pending.size() == 0) begin
                report("output frame with no request outstanding");
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (!want.silent) n_audible++;
            if (want.finished) n_done++;
            if (got.left !== want.left)
                report($sformatf("left_out %0d, expected %0d", got.left, want.left));
            if (got.right !== want.right)
                report($sformatf("right_out %0d, expected %0d", got.right, want.right));
            if (got.silent !== want.silent)
                report($sformatf("silent %b, expected %b", got.silent, want.silent));
            if (got.finished !== want.finished)
                report($sformatf("finished %b, expected %b", got.finished, want.finished));
            if (got.playing !== want.playing)
                report($sformatf("playing %b, expected %b", got.playing, want.playing));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [REQ_W-1:0]              i_req_type;
    logic                          i_sample_channel;
    logic [ADDR_IN_W-1:0]          i_sample_address;
    logic signed [15:0]            i_sample_value;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [15:0]            o_left_out;
    logic signed [15:0]            o_right_out;
    logic                          o_silent;
    logic                          o_finished;
    logic                          o_playing;

    voice_scoreboard board;
    int send_idle;
    int recv_idle;
    int items_sent;
    int cfg_writes;
    int settings;

    sample_playback_voice_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_sample_channel (i_sample_channel),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_silent         (o_silent),
        .o_finished       (o_finished),
        .o_playing        (o_playing)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // output side back-pressure
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin : out_mon
        t_voice_frame got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.left     = o_left_out;
            got.right    = o_right_out;
            got.silent   = o_silent;
            got.finished = o_finished;
            got.playing  = o_playing;
            board.check(got);
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", quiet);
            $display("FAIL sample_playback_voice_core");
            $finish;
        end
    end

    task automatic set_pace(int mode);
        case (mode)
            0: begin send_idle = 21; recv_idle = 76; end
            1: begin send_idle = 76; recv_idle = 21; end
            default: begin send_idle = 0; recv_idle = 0; end
        endcase
    endtask

    task automatic send_item(t_req req, logic ch, logic [15:0] addr, logic [15:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= req;
        i_sample_channel <= ch;
        i_sample_address <= addr;
        i_sample_value   <= val;
        do @(posedge i_clk); while (!o_in_ready);
        board.note(req, ch, addr, val);
        items_sent++;
    endtask

    task automatic send_op(t_req req);
        send_item(req, $urandom, $urandom, $urandom);
    endtask

    // fill any sample the next frame will read before rendering it
    task automatic render();
        int unsigned idx, nxt;
        bit [63:0]   frac, p;
        int          ch;
        if (board.will_play()) begin
            board.locate(idx, nxt, frac, p);
            for (ch = 0; ch < board.eff_chans(); ch++) begin
                if (!board.written[ch][idx]) send_item(REQ_WRITE, ch[0], idx[15:0], $urandom);
                if (!board.written[ch][nxt]) send_item(REQ_WRITE, ch[0], nxt[15:0], $urandom);
            end
        end
        send_op(REQ_RENDER);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        settings++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, d);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random upper bits above a register's width
    function automatic logic [31:0] junk(logic [31:0] v, int w);
        return ($urandom << w) | v;
    endfunction

    function automatic logic [31:0] near_frame(int span);
        return board.frame_no + $urandom_range(span);
    endfunction

    task automatic shuffle_settings();
        int          r;
        logic [31:0] v;
        write_reg(CFG_LOOP_MODE, junk($urandom_range(1), 1));

        r = $urandom_range(99);
        if (r < 10) v = 0;
        else if (r < 20) v = 32'h7FFFF;
        else if (r < 55) v = $urandom_range(131072);
        else v = $urandom & 32'h7FFFF;
        write_reg(CFG_PLAYBACK_RATE, junk(v, RATE_W));

        r = $urandom_range(99);
        if (r < 50) v = near_frame(20);
        else if (r < 65) v = 0;
        else if (r < 80) v = board.frame_no - $urandom_range(50);
        else if (r < 90) v = '1;
        else v = $urandom;
        write_reg(CFG_START_FRAME, v);

        r = $urandom_range(99);
        if (r < 40) v = near_frame(120);
        else if (r < 60) v = '1;
        else if (r < 75) v = near_frame(10);
        else v = $urandom;
        write_reg(CFG_PLAY_END_FRAME, v);

        r = $urandom_range(99);
        if (r < 35) v = near_frame(120);
        else if (r < 65) v = '1;
        else if (r < 80) v = near_frame(10);
        else v = $urandom;
        write_reg(CFG_STOP_FRAME, v);

        v = ($urandom_range(1) == 0) ? $urandom_range(70) : ($urandom & 32'hFFFF);
        write_reg(CFG_START_OFFSET, junk(v, OFFSET_W));

        r = $urandom_range(99);
        if (r < 70) v = $urandom_range(8, 64);
        else if (r < 78) v = $urandom_range(65, 4096);
        else if (r < 84) v = DEPTH;
        else if (r < 88) v = 0;
        else if (r < 92) v = $urandom_range(DEPTH + 1, 131071);
        else v = $urandom_range(1, 7);
        write_reg(CFG_BUFFER_LENGTH, junk(v, BLEN_W));

        write_reg(CFG_CHANNEL_COUNT, junk($urandom_range(3), CCNT_W));
    endtask

    // mostly a fresh note followed by frames, with stray requests mixed in
    task automatic play_phase(int n);
        int k;
        int r;
        if ($urandom_range(99) < 85) begin
            if ($urandom_range(99) < 85) send_op(REQ_ATTACH);
            send_op(REQ_ARM);
        end
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 72) render();
            else if (r < 79) send_op(REQ_ARM);
            else if (r < 83) send_op(REQ_ATTACH);
            else if (r < 91) send_item(REQ_WRITE, $urandom, 16'($urandom_range(127)), $urandom);
            else send_op(REQ_WRITE);
        end
    endtask

    initial begin
        int base;
        board            = new();
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_req_type       = '0;
        i_sample_channel = 1'b0;
        i_sample_address = '0;
        i_sample_value   = '0;
        items_sent       = 0;
        cfg_writes       = 0;
        settings         = 1;
        set_pace(0);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: silent before attach, arm ignored without attach
        render();
        send_op(REQ_ARM);
        send_item(REQ_WRITE, 1'b0, 16'h0000, 16'h8000);
        send_item(REQ_WRITE, 1'b1, 16'hFFFF, 16'h7FFF);
        send_item(REQ_WRITE, 1'b0, 16'h0001, 16'h7FFF);
        send_op(REQ_ATTACH);
        render();
        send_op(REQ_ARM);
        repeat (3) render();

        // delayed start, end of natural playback, stereo, offset past length
        settle();
        write_reg(CFG_LOOP_MODE, 0);
        write_reg(CFG_PLAYBACK_RATE, 32'h7FFFF);
        write_reg(CFG_START_FRAME, board.frame_no + 2);
        write_reg(CFG_PLAY_END_FRAME, board.frame_no + 4);
        write_reg(CFG_STOP_FRAME, '1);
        write_reg(CFG_START_OFFSET, 32'hFFFF);
        write_reg(CFG_BUFFER_LENGTH, 8);
        write_reg(CFG_CHANNEL_COUNT, 2);
        send_op(REQ_ARM);
        repeat (6) render();

        // loop mode ends on the stop frame; zero length and channel count
        settle();
        write_reg(CFG_LOOP_MODE, 1);
        write_reg(CFG_PLAYBACK_RATE, 0);
        write_reg(CFG_START_FRAME, 0);
        write_reg(CFG_PLAY_END_FRAME, board.frame_no);
        write_reg(CFG_STOP_FRAME, board.frame_no + 1);
        write_reg(CFG_START_OFFSET, 3);
        write_reg(CFG_BUFFER_LENGTH, 0);
        write_reg(CFG_CHANNEL_COUNT, 0);
        send_op(REQ_ARM);
        repeat (3) render();

        // stop frame already behind the counter; oversize length and count
        settle();
        write_reg(CFG_LOOP_MODE, 0);
        write_reg(CFG_STOP_FRAME, 0);
        write_reg(CFG_PLAY_END_FRAME, '1);
        write_reg(CFG_BUFFER_LENGTH, 32'h1FFFF);
        write_reg(CFG_CHANNEL_COUNT, 3);
        write_reg(CFG_PLAYBACK_RATE, 32'h18000);
        send_op(REQ_ARM);
        render();

        // leave the voice playing, then shrink the buffer under it
        settle();
        write_reg(CFG_STOP_FRAME, '1);
        write_reg(CFG_BUFFER_LENGTH, 64);
        write_reg(CFG_START_OFFSET, 40);
        write_reg(CFG_PLAYBACK_RATE, 32'h38000);
        write_reg(CFG_CHANNEL_COUNT, 2);
        send_op(REQ_ARM);
        repeat (2) render();
        settle();
        write_reg(CFG_BUFFER_LENGTH, 8);
        repeat (2) render();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            set_pace((items_sent - base) * 3 / RANDOM_ITEMS);
            settle();
            shuffle_settings();
            play_phase($urandom_range(60, 140));
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending.size() != 0)
            board.report($sformatf("%0d output frames never arrived", board.pending.size()));
        $display("%0d requests in, %0d frames checked, %0d audible, %0d note completions",
                 items_sent, board.n_checked, board.n_audible, board.n_done);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, settings, board.errors);
        if (board.errors == 0) begin
            $display("PASS sample_playback_voice_core");
        end else begin
            $display("FAIL sample_playback_voice_core");
        end
        $finish;
    end

endmodule

// ===== sample_playback_voice_core.f =====
design/svp_pkg.sv
design/svp_ram.sv
design/svp_recalc.sv
design/svp_lane.sv
design/sample_playback_voice_core.sv
tb/tb.sv
